### rtl/pgpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpt_pkg: shared types and constants
// Transaction payload types, controller/datapath interface structs and the
// squared bin-edge function for the patch gradient threshold core.
// ----------------------------------------------------------------------------
package pgpt_pkg;

	// Field widths that do not vary with the core's parameters.
	localparam int GRAD_W   = 24;
	localparam int CNT_W    = 13;
	localparam int BIAS_W   = 16;
	localparam int BINF_W   = 6;
	localparam int REM_W    = CNT_W + 2;
	localparam int SUM_W    = 18;
	localparam int CFG_IX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] REG_TARGET_COUNT = 1'b0;
	localparam logic [CFG_IX_W-1:0] REG_THRESH_BIAS  = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [BIAS_W-1:0] BIAS_RST = 16'd1792;

	// One pixel transaction.
	typedef struct packed {
		logic [GRAD_W-1:0] grad_sq;
		logic              last_in_patch;
	} pgpt_in_t;

	// One threshold transaction.
	typedef struct packed {
		logic signed [BIAS_W-1:0] threshold;
		logic [BINF_W-1:0]        percentile_bin;
	} pgpt_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic step;
		logic rd_bin;
		logic upd_write;
		logic scan_init;
		logic rd_scan;
		logic scan_eval;
		logic out_load;
	} pgpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic probe_last;
		logic last_item;
		logic idx_end;
		logic rem_hit;
		logic out_free;
	} pgpt_stat_t;

	// Lower edge of bin k in Q16.8: (k-0.5)^2 = 256*(k*k-k)+64.
	function automatic logic [GRAD_W-1:0] bin_edge(input logic [BINF_W-1:0] k);
		logic [2*BINF_W-1:0] kk;
		logic [2*BINF_W-1:0] kd;
		kk = {{BINF_W{1'b0}}, k} * {{BINF_W{1'b0}}, k};
		kd = kk - {{BINF_W{1'b0}}, k};
		return {{(GRAD_W-2*BINF_W-8){1'b0}}, kd, 8'h40};
	endfunction

endpackage

### rtl/pgpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pgpt_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 50
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/pgpt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpt_datapath: histogram datapath
// Holds the configuration registers, the bin search unit, the histogram
// memory with its valid bits, the percentile scan and the result register.
// ----------------------------------------------------------------------------
module pgpt_datapath #(
	parameter int NUM_BINS   = 50,
	parameter int TARGET_RST = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pgpt_pkg::pgpt_cmd_t                 cmd,
	output pgpt_pkg::pgpt_stat_t                stat,
	input  pgpt_pkg::pgpt_in_t                  pix,
	input  logic                                cfg_we,
	input  logic [pgpt_pkg::CFG_IX_W-1:0]       cfg_index,
	input  logic [pgpt_pkg::BIAS_W-1:0]         cfg_wdata,
	output logic                                res_valid,
	input  logic                                res_stall,
	output pgpt_pkg::pgpt_out_t                 res
);

	localparam int BIN_W   = $clog2(NUM_BINS);
	localparam int FOUND_W = $clog2(NUM_BINS + 1);
	localparam logic [BIN_W:0]   LAST_BIN = (BIN_W + 1)'(NUM_BINS - 1);
	localparam logic [BIN_W:0]   NBINS_X  = (BIN_W + 1)'(NUM_BINS);
	localparam logic [FOUND_W-1:0] IDX_END = FOUND_W'(NUM_BINS);
	localparam logic [BIN_W-1:0] PROBE_MSB = {1'b1, {(BIN_W-1){1'b0}}};

	// Configuration registers.
	logic [pgpt_pkg::CNT_W-1:0]  target_q;
	logic [pgpt_pkg::BIAS_W-1:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= pgpt_pkg::CNT_W'(TARGET_RST);
			bias_q   <= pgpt_pkg::BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pgpt_pkg::REG_TARGET_COUNT: target_q <= cfg_wdata[pgpt_pkg::CNT_W-1:0];
				pgpt_pkg::REG_THRESH_BIAS:  bias_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Captured pixel and bin search state.
	logic [pgpt_pkg::GRAD_W-1:0] grad_q;
	logic                        last_q;
	logic [BIN_W-1:0]            bin_q;
	logic [BIN_W-1:0]            probe_q;
	logic [BIN_W-1:0]            cand;
	logic                        cand_ok;

	// One bit of the bin index is decided per step, most significant first.
	assign cand    = bin_q | probe_q;
	assign cand_ok = ((BIN_W + 1)'(cand) <= LAST_BIN) &&
		(grad_q >= pgpt_pkg::bin_edge(pgpt_pkg::BINF_W'(cand)));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			grad_q  <= pix.grad_sq;
			last_q  <= pix.last_in_patch;
			bin_q   <= '0;
			probe_q <= PROBE_MSB;
		end else if (cmd.step) begin
			if (cand_ok) begin
				bin_q <= cand;
			end
			probe_q <= probe_q >> 1;
		end
	end

	// Histogram memory; an entry without its valid bit reads as zero.
	logic [NUM_BINS-1:0]        valid_q;
	logic                       vld_rd_q;
	logic [BIN_W-1:0]           raddr;
	logic [pgpt_pkg::CNT_W-1:0] rdata;
	logic [pgpt_pkg::CNT_W-1:0] count;
	logic [pgpt_pkg::CNT_W-1:0] count_inc;
	logic [FOUND_W-1:0]         idx_q;

	assign raddr     = cmd.rd_scan ? idx_q[BIN_W-1:0] : bin_q;
	assign count     = vld_rd_q ? rdata : '0;
	assign count_inc = (count == pgpt_pkg::COUNT_MAX) ? count : count + 1'b1;

	pgpt_ram #(
		.WIDTH(pgpt_pkg::CNT_W),
		.DEPTH(NUM_BINS)
	) u_hist (
		.clk  (clk),
		.we   (cmd.upd_write),
		.waddr(bin_q),
		.wdata(count_inc),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.rd_bin || cmd.rd_scan) begin
				vld_rd_q <= ((BIN_W + 1)'(raddr) < NBINS_X) && valid_q[raddr];
			end
			if (cmd.out_load) begin
				valid_q <= '0;
			end else if (cmd.upd_write) begin
				valid_q[bin_q] <= 1'b1;
			end
		end
	end

	// Percentile scan: subtract each bin count from the target.
	logic signed [pgpt_pkg::REM_W-1:0] remain_q;
	logic signed [pgpt_pkg::REM_W-1:0] rem_next;
	logic                              rem_hit;

	assign rem_next = remain_q - $signed({2'b00, count});
	assign rem_hit  = rem_next[pgpt_pkg::REM_W-1] || (rem_next == '0);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			remain_q <= $signed({2'b00, target_q});
			idx_q    <= '0;
		end else if (cmd.scan_eval) begin
			remain_q <= rem_next;
			if (!rem_hit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Threshold: bin in Q8.8 plus bias, saturated to 16 bits.
	logic signed [pgpt_pkg::SUM_W-1:0] sum;
	logic signed [pgpt_pkg::BIAS_W-1:0] thr;

	assign sum = $signed({{(pgpt_pkg::SUM_W-FOUND_W-8){1'b0}}, idx_q, 8'h00})
		+ $signed({{(pgpt_pkg::SUM_W-pgpt_pkg::BIAS_W){bias_q[pgpt_pkg::BIAS_W-1]}}, bias_q});

	always_comb begin
		if (!sum[pgpt_pkg::SUM_W-1] && (sum[pgpt_pkg::SUM_W-2:pgpt_pkg::BIAS_W-1] != '0)) begin
			thr = 16'sh7FFF;
		end else if (sum[pgpt_pkg::SUM_W-1] &&
			(sum[pgpt_pkg::SUM_W-2:pgpt_pkg::BIAS_W-1] != '1)) begin
			thr = -16'sh8000;
		end else begin
			thr = sum[pgpt_pkg::BIAS_W-1:0];
		end
	end

	// Result register.
	logic                res_valid_q;
	pgpt_pkg::pgpt_out_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.threshold      <= thr;
			res_q.percentile_bin <= pgpt_pkg::BINF_W'(idx_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Status back to the controller.
	assign stat.probe_last = probe_q[0];
	assign stat.last_item  = last_q;
	assign stat.idx_end    = (idx_q == IDX_END);
	assign stat.rem_hit    = rem_hit;
	assign stat.out_free   = !res_valid_q || !res_stall;

endmodule

### rtl/pgpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpt_ctrl: sequencing controller
// Walks each pixel through bin search and histogram update, and on the last
// pixel of a patch through the percentile scan and result hand-off.
// ----------------------------------------------------------------------------
module pgpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pgpt_pkg::pgpt_stat_t stat,
	output pgpt_pkg::pgpt_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_UPD    = 3'd3;
	localparam logic [2:0] ST_SC_RD  = 3'd4;
	localparam logic [2:0] ST_SC_EV  = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (stat.probe_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_bin = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_write = 1'b1;
				if (stat.last_item) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SC_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SC_RD: begin
				if (stat.idx_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.rd_scan = 1'b1;
					state_d     = ST_SC_EV;
				end
			end
			ST_SC_EV: begin
				cmd.scan_eval = 1'b1;
				state_d       = stat.rem_hit ? ST_FIN : ST_SC_RD;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign pix_stall = (state_q != ST_IDLE);

endmodule

### rtl/patch_gradient_percentile_threshold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_gradient_percentile_threshold_core: patch gradient threshold
// Builds a histogram of pixel gradient magnitudes per patch and emits the
// percentile bin plus a bias as the patch threshold.
// ----------------------------------------------------------------------------
// For each pixel transaction the bin is found by a binary search over the
// squared bin edges, one compare per cycle, followed by a read and a write of
// the histogram memory through its single read and single write port. The
// pixel flagged last of a patch adds the percentile scan, a read and then an
// evaluation per bin visited, since every bin is read from the same memory
// port, and a result load; the histogram is then cleared at once through
// its valid bits. A result waiting on res_stall holds off only the end of
// the next patch, not its pixels.
module patch_gradient_percentile_threshold_core #(
	parameter int PATCH_SIDE = 32,
	parameter int NUM_BINS   = 50
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  pgpt_pkg::pgpt_in_t            pix,
	output logic                          res_valid,
	input  logic                          res_stall,
	output pgpt_pkg::pgpt_out_t           res,
	input  logic                          cfg_we,
	input  logic [pgpt_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [pgpt_pkg::BIAS_W-1:0]   cfg_wdata
);

	localparam int TARGET_RST = (PATCH_SIDE * PATCH_SIDE / 2) % (1 << pgpt_pkg::CNT_W);

	pgpt_pkg::pgpt_cmd_t  cmd;
	pgpt_pkg::pgpt_stat_t stat;

	// Controller.
	pgpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath.
	pgpt_datapath #(
		.NUM_BINS  (NUM_BINS),
		.TARGET_RST(TARGET_RST)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.pix      (pix),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

### rtl/pgpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpt_checker: port-level assertions
// Checks handshake behavior and result ranges seen at the core's ports.
// ----------------------------------------------------------------------------
module pgpt_checker #(
	parameter int NUM_BINS = 50
) (
	input logic                clk,
	input logic                arst_n,
	input logic                pix_valid,
	input logic                pix_stall,
	input pgpt_pkg::pgpt_in_t  pix,
	input logic                res_valid,
	input logic                res_stall,
	input pgpt_pkg::pgpt_out_t res
);

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Pixels are never accepted back to back; each one occupies the core.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("pixel accepted in back-to-back cycles");

	// A new result only appears at the end of work on a patch.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_stall))
		else $error("result appeared while the core was idle");

	// The reported bin never exceeds the bin count.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (NUM_BINS >= 64) || (res.percentile_bin <= NUM_BINS))
		else $error("percentile bin out of range");

	// The last-pixel flag is a known value whenever a pixel is offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |-> !$isunknown(pix.last_in_patch))
		else $error("unknown last-pixel flag");

endmodule

bind patch_gradient_percentile_threshold_core pgpt_checker #(
	.NUM_BINS(NUM_BINS)
) u_pgpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall),
	.pix      (pix),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);
